[sv/signed_interval_alu_macros.svh]
// Assertion macros used by the checker file.
`ifndef SIGNED_INTERVAL_ALU_MACROS_SVH
`define SIGNED_INTERVAL_ALU_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SIA_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("signed_interval_alu: same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define SIA_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("signed_interval_alu: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define SIA_ASSERT_ALWAYS(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) (ant) |=> (cons)) \
    else $error("signed_interval_alu: reset check failed");

`endif

[sv/sia_pkg.sv]
package sia_pkg;

  localparam int DW  = 32;
  localparam int SHW = $clog2(DW);
  localparam int NLANE = 4;

  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};

  localparam logic [1:0] TAG_REGULAR = 2'd0;
  localparam logic [1:0] TAG_EMPTY   = 2'd1;
  localparam logic [1:0] TAG_UNKNOWN = 2'd2;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_UDIV  = 4'd3,
    OP_SDIV  = 4'd4,
    OP_UREM  = 4'd5,
    OP_SREM  = 4'd6,
    OP_SHL   = 4'd7,
    OP_LSHR  = 4'd8,
    OP_ASHR  = 4'd9,
    OP_AND   = 4'd10,
    OP_OR    = 4'd11,
    OP_XOR   = 4'd12,
    OP_TRUNC = 4'd13,
    OP_ISECT = 4'd14,
    OP_UNION = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    MODE_DIRECT  = 2'd0,
    MODE_CORNERS = 2'd1,
    MODE_DIV     = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t         mode;
    logic [DW-1:0] lo;
    logic [DW-1:0] hi;
    logic [1:0]    tag;
  } carry_t;

  function automatic logic slt(input logic [DW-1:0] x, input logic [DW-1:0] y);
    return $signed(x) < $signed(y);
  endfunction

  function automatic logic [DW-1:0] smin(input logic [DW-1:0] x, input logic [DW-1:0] y);
    return slt(y, x) ? y : x;
  endfunction

  function automatic logic [DW-1:0] smax(input logic [DW-1:0] x, input logic [DW-1:0] y);
    return slt(x, y) ? y : x;
  endfunction

  // A result whose lower bound lies above its upper bound is empty.
  function automatic carry_t mk(input logic [DW-1:0] l, input logic [DW-1:0] u);
    carry_t r;
    r.mode = MODE_DIRECT;
    r.lo   = l;
    r.hi   = u;
    r.tag  = slt(u, l) ? TAG_EMPTY : TAG_REGULAR;
    return r;
  endfunction

  function automatic carry_t mkt(input logic [DW-1:0] l, input logic [DW-1:0] u,
                                 input logic [1:0] t);
    carry_t r;
    r.mode = MODE_DIRECT;
    r.lo   = l;
    r.hi   = u;
    r.tag  = t;
    return r;
  endfunction

endpackage

[sv/sia_if.sv]
interface sia_in_if import sia_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [3:0]           kind;
  logic signed [DW-1:0] a_low;
  logic signed [DW-1:0] a_high;
  logic [1:0]           a_tag;
  logic signed [DW-1:0] b_low;
  logic signed [DW-1:0] b_high;
  logic [1:0]           b_tag;
  logic [5:0]           target_bits;

  modport source (output valid, kind, a_low, a_high, a_tag, b_low, b_high, b_tag,
                  target_bits, input ready);
  modport sink (input valid, kind, a_low, a_high, a_tag, b_low, b_high, b_tag,
                target_bits, output ready);
endinterface

interface sia_out_if import sia_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] r_low;
  logic signed [DW-1:0] r_high;
  logic [1:0]           r_tag;

  modport source (output valid, r_low, r_high, r_tag, input ready);
  modport sink (input valid, r_low, r_high, r_tag, output ready);
endinterface

[sv/signed_interval_alu.sv]
// Signed interval ALU. It takes one item per clock cycle while the output does
// not stall and presents each result in order; an output stall delays it. The
// pipeline depth is set by the four corner lanes, each of which holds a
// 32-stage restoring divider that yields one quotient bit per stage; multiplies
// and shifts ride the same lanes, and a merge stage takes the minimum and
// maximum of the lane results for corner operations. A stall at the output
// backs up only through full stages, so the input keeps taking items while any
// stage is empty.
module signed_interval_alu import sia_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  sia_in_if.sink  in_if,
  sia_out_if.source out_if
);

  localparam int LAST = DW + 1;

  logic [LAST:0] en;
  logic          vld_r [0:LAST];
  carry_t        car_r [0:DW];
  carry_t        car0;
  logic [DW-1:0] lane_x [NLANE];
  logic [DW-1:0] lane_y [NLANE];
  logic          lane_live [NLANE];
  logic [DW-1:0] lane_dflt [NLANE];
  logic [DW-1:0] lane_k [NLANE];
  logic [DW-1:0] m_lo, m_hi, lo_r, hi_r;
  logic [1:0]    m_tag, tag_r;

  always_comb begin
    en[LAST] = !vld_r[LAST] || out_if.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_if.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= LAST; i++) vld_r[i] <= 1'b0;
    end else begin
      if (en[0]) vld_r[0] <= in_if.valid;
      for (int i = 1; i <= LAST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  sia_front u_front (
    .kind        (op_t'(in_if.kind)),
    .a           (in_if.a_low),
    .b           (in_if.a_high),
    .a_tag       (in_if.a_tag),
    .c           (in_if.b_low),
    .d           (in_if.b_high),
    .b_tag       (in_if.b_tag),
    .target_bits (in_if.target_bits),
    .car         (car0),
    .lane_x      (lane_x),
    .lane_y      (lane_y),
    .lane_live   (lane_live),
    .lane_dflt   (lane_dflt)
  );

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    sia_lane u_lane (
      .clk  (clk),
      .en   (en[DW:0]),
      .kind (op_t'(in_if.kind)),
      .x    (lane_x[g]),
      .y    (lane_y[g]),
      .live (lane_live[g]),
      .dflt (lane_dflt[g]),
      .k    (lane_k[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en[0]) car_r[0] <= car0;
    for (int i = 1; i <= DW; i++) begin
      if (en[i]) car_r[i] <= car_r[i-1];
    end
  end

  sia_merge u_merge (
    .car (car_r[DW]),
    .k   (lane_k),
    .lo  (m_lo),
    .hi  (m_hi),
    .tag (m_tag)
  );

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      lo_r  <= m_lo;
      hi_r  <= m_hi;
      tag_r <= m_tag;
    end
  end

  assign out_if.valid  = vld_r[LAST];
  assign out_if.r_low  = lo_r;
  assign out_if.r_high = hi_r;
  assign out_if.r_tag  = tag_r;

endmodule

[sv/sia_front.sv]
module sia_front import sia_pkg::*; (
  input  op_t           kind,
  input  logic [DW-1:0] a,
  input  logic [DW-1:0] b,
  input  logic [1:0]    a_tag,
  input  logic [DW-1:0] c,
  input  logic [DW-1:0] d,
  input  logic [1:0]    b_tag,
  input  logic [5:0]    target_bits,
  output carry_t        car,
  output logic [DW-1:0] lane_x [NLANE],
  output logic [DW-1:0] lane_y [NLANE],
  output logic          lane_live [NLANE],
  output logic [DW-1:0] lane_dflt [NLANE]
);

  localparam logic [63:0] LOW_ONES = 64'h0000_0000_FFFF_FFFF;

  function automatic logic le64(input logic [63:0] x, input logic [63:0] y);
    return $signed(x) <= $signed(y);
  endfunction

  // Lowest value of x | y for x in [a, b] and y in [c, d]; the highest bit that
  // allows a raise of one lower bound decides.
  function automatic logic [63:0] min_or(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] c, input logic [63:0] d);
    logic [63:0] res;
    logic [63:0] m;
    logic [63:0] t;
    res = a | c;
    for (int i = 0; i < 32; i++) begin
      m = 64'd1 << i;
      if (!a[i] && c[i]) begin
        t = (a | m) & (~m + 64'd1);
        if (le64(t, b)) res = t | c;
      end else if (a[i] && !c[i]) begin
        t = (c | m) & (~m + 64'd1);
        if (le64(t, d)) res = a | t;
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] max_or(input logic [63:0] a, input logic [63:0] b,
                                         input logic [63:0] c, input logic [63:0] d);
    logic [63:0] res;
    logic [63:0] m;
    logic [63:0] t;
    logic [63:0] t2;
    res = b | d;
    for (int i = 0; i < 32; i++) begin
      m = 64'd1 << i;
      if (b[i] && d[i]) begin
        t  = (b - m) | (m - 64'd1);
        t2 = (d - m) | (m - 64'd1);
        if (le64(a, t)) res = t | d;
        else if (le64(c, t2)) res = b | t2;
      end
    end
    return res;
  endfunction

  function automatic carry_t pass(input logic [DW-1:0] l, input logic [DW-1:0] u,
                                  input logic [1:0] t);
    return mkt(l, u, (t == 2'd3) ? TAG_UNKNOWN : t);
  endfunction

  logic [DW-1:0] sum_lo, sum_hi, add_lo, add_hi, and_m, dm, tr_p, tr_top, tr_bot;
  logic [5:0]    tr_w;
  logic [63:0]   sa, sb, sc, sd, mn_a, mn_b, mn_d, mx_a, mx_c, mn_res, mx_res;
  logic [3:0]    sw;
  logic          full_a, full_c, u0, u1, u2, u3;

  always_comb begin
    sum_lo = a + c;
    sum_hi = b + d;
    add_lo = VMIN;
    add_hi = VMAX;
    if (a != VMIN && c != VMIN) begin
      add_lo = (a[DW-1] == c[DW-1] && a[DW-1] != sum_lo[DW-1]) ? VMIN : sum_lo;
    end
    if (b != VMAX && d != VMAX) begin
      add_hi = (b[DW-1] == d[DW-1] && b[DW-1] != sum_hi[DW-1]) ? VMAX : sum_hi;
    end

    and_m = (b < d) ? b : d;
    dm    = (c == '0) ? {{(DW-1){1'b0}}, 1'b1} : c;

    tr_w   = (target_bits == 6'd0) ? 6'd1 :
             (target_bits > 6'(DW)) ? 6'(DW) : target_bits;
    tr_p   = {{(DW-1){1'b0}}, 1'b1} << (tr_w - 6'd1);
    tr_top = tr_p - {{(DW-1){1'b0}}, 1'b1};
    tr_bot = ~tr_p + {{(DW-1){1'b0}}, 1'b1};

    sa = {{(64-DW){a[DW-1]}}, a};
    sb = {{(64-DW){b[DW-1]}}, b};
    sc = {{(64-DW){c[DW-1]}}, c};
    sd = {{(64-DW){d[DW-1]}}, d};
    sw = {!a[DW-1], !b[DW-1], !c[DW-1], !d[DW-1]};
    mn_a = sa;
    mn_b = sb;
    mn_d = sd;
    mx_a = sa;
    mx_c = sc;
    unique case (sw)
      4'd5: begin
        mx_a = '0;
        mx_c = '0;
      end
      4'd7: begin
        mn_b = LOW_ONES;
        mx_a = '0;
      end
      4'd13: begin
        mn_d = LOW_ONES;
        mx_c = '0;
      end
      default: begin
        mn_b = sb;
      end
    endcase
    mn_res = min_or(mn_a, mn_b, sc, mn_d);
    mx_res = max_or(mx_a, sb, mx_c, sd);

    full_a = (a == VMIN) && (b == VMAX);
    full_c = (c == VMIN) && (d == VMAX);
    u0 = (a != VMIN) && (c != VMIN);
    u1 = (a != VMIN) && (d != VMAX);
    u2 = (b != VMAX) && (c != VMIN);
    u3 = (b != VMAX) && (d != VMAX);

    lane_x    = '{a, a, b, b};
    lane_y    = '{c, d, c, d};
    lane_live = '{u0, u1, u2, u3};
    lane_dflt = '{VMIN, VMIN, VMAX, VMAX};

    car = mk(VMIN, VMAX);
    unique case (kind)
      OP_ADD: car = mk(add_lo, add_hi);
      OP_SUB: car = mk((a == VMIN || d == VMAX) ? VMIN : a - d,
                       (b == VMAX || c == VMIN) ? VMAX : b - c);
      OP_MUL: begin
        lane_live = '{1'b1, 1'b1, 1'b1, 1'b1};
        if (!full_a && !full_c) car.mode = MODE_CORNERS;
      end
      OP_UDIV, OP_SDIV: begin
        lane_x    = '{a, b, a, b};
        lane_y    = '{d, dm, d, dm};
        lane_live = '{1'b1, 1'b1, 1'b1, 1'b1};
        if (a_tag != TAG_EMPTY && b_tag != TAG_EMPTY && d != '0 && !full_c) begin
          car.mode = MODE_DIV;
        end
      end
      OP_UREM: begin
        if (c != '0 && d != '0) car.mode = MODE_CORNERS;
      end
      OP_SREM: begin
        if ((b_tag == TAG_REGULAR && c == '0 && d == '0) ||
            (b_tag == TAG_EMPTY && full_c)) begin
          car = mkt(VMIN, VMAX, TAG_EMPTY);
        end else if (!((c[DW-1] && !d[DW-1] && d != '0) || c == '0 || d == '0)) begin
          car.mode = MODE_CORNERS;
        end
      end
      OP_SHL, OP_ASHR: car.mode = MODE_CORNERS;
      OP_LSHR: begin
        if (a[DW-1] || b[DW-1]) car = mk('0, VMAX);
        else car.mode = MODE_CORNERS;
      end
      OP_AND: begin
        if (a_tag == TAG_EMPTY || b_tag == TAG_EMPTY) car = mkt(VMIN, VMAX, TAG_EMPTY);
        else if (and_m == '1) car = mk(VMIN, VMAX);
        else car = mk('0, and_m);
      end
      OP_OR: begin
        if (a_tag[1] || b_tag[1]) begin
          car = mkt(VMIN, VMAX, TAG_UNKNOWN);
        end else begin
          unique case (sw)
            4'd0, 4'd3, 4'd12, 4'd15: car = mk(mn_res[DW-1:0], mx_res[DW-1:0]);
            4'd1:  car = mk(a, '1);
            4'd4:  car = mk(c, '1);
            4'd5:  car = mk(smin(a, c), mx_res[DW-1:0]);
            4'd7, 4'd13: car = mk(mn_res[DW-1:0], mx_res[DW-1:0]);
            default: car = mk(VMIN, VMAX);
          endcase
        end
      end
      OP_XOR: car = mk(VMIN, VMAX);
      OP_TRUNC: begin
        if (!slt(a, tr_bot) && !slt(tr_top, b)) car = pass(a, b, a_tag);
        else car = mk(tr_bot, tr_top);
      end
      OP_ISECT: begin
        if (a_tag == TAG_EMPTY || b_tag == TAG_EMPTY) car = mkt(VMIN, VMAX, TAG_EMPTY);
        else if (a_tag[1]) car = pass(c, d, b_tag);
        else if (b_tag[1]) car = pass(a, b, a_tag);
        else car = mk(smax(a, c), smin(b, d));
      end
      OP_UNION: begin
        if (a_tag == TAG_EMPTY) car = pass(c, d, b_tag);
        else if (b_tag == TAG_EMPTY) car = pass(a, b, a_tag);
        else if (a_tag[1]) car = pass(c, d, b_tag);
        else if (b_tag[1]) car = pass(a, b, a_tag);
        else car = mk(smin(a, c), smax(b, d));
      end
    endcase
  end

endmodule

[sv/sia_lane.sv]
module sia_lane import sia_pkg::*; (
  input  logic          clk,
  input  logic [DW:0]   en,
  input  op_t           kind,
  input  logic [DW-1:0] x,
  input  logic [DW-1:0] y,
  input  logic          live,
  input  logic [DW-1:0] dflt,
  output logic [DW-1:0] k
);

  typedef struct packed {
    op_t           kind;
    logic          negq;
    logic          negr;
    logic          live;
    logic [DW-1:0] dflt;
    logic [DW-1:0] val;
  } side_t;

  side_t         side_r [0:DW];
  logic [DW-1:0] rem_r  [0:DW];
  logic [DW-1:0] dvd_r  [0:DW];
  logic [DW-1:0] dsr_r  [0:DW];
  logic [DW-1:0] prod_r, specv_r;
  logic          spec_r, samepos_r;

  logic [DW-1:0] magx, magy, shv, prod, specv, p, mulv, q, r, res;
  logic          spec, xpos, ypos;
  logic [SHW-1:0] sh;
  logic          big;
  side_t         side0;

  always_comb begin
    magx = x[DW-1] ? ~x + DW'(1) : x;
    magy = y[DW-1] ? ~y + DW'(1) : y;
    sh   = y[SHW-1:0];
    big  = |y[DW-1:SHW];
    prod = x * y;
    xpos = !x[DW-1] && x != '0;
    ypos = !y[DW-1] && y != '0;

    spec  = 1'b1;
    specv = '0;
    if (x == VMAX) specv = y[DW-1] ? VMIN : (y == '0 ? '0 : VMAX);
    else if (y == VMAX) specv = x[DW-1] ? VMIN : (x == '0 ? '0 : VMAX);
    else if (x == VMIN) specv = y[DW-1] ? VMAX : (y == '0 ? '0 : VMIN);
    else if (y == VMIN) specv = x[DW-1] ? VMAX : (x == '0 ? '0 : VMIN);
    else spec = 1'b0;

    unique case (kind)
      OP_SHL:  shv = big ? '0 : x << sh;
      OP_LSHR: shv = big ? '0 : x >> sh;
      OP_ASHR: shv = big ? {DW{x[DW-1]}} : DW'($signed(x) >>> sh);
      default: shv = prod;
    endcase

    side0.kind = kind;
    side0.negq = x[DW-1] ^ y[DW-1];
    side0.negr = x[DW-1];
    side0.live = live;
    side0.dflt = dflt;
    side0.val  = shv;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side0;
      rem_r[0]  <= '0;
      prod_r    <= prod;
      specv_r   <= specv;
      spec_r    <= spec;
      samepos_r <= xpos == ypos;
      if (kind == OP_SDIV || kind == OP_SREM) begin
        dvd_r[0] <= magx;
        dsr_r[0] <= magy;
      end else begin
        dvd_r[0] <= x;
        dsr_r[0] <= y;
      end
    end
  end

  always_comb begin
    p = spec_r ? specv_r : prod_r;
    if (samepos_r) mulv = p[DW-1] ? VMAX : p;
    else mulv = (!p[DW-1] && p != '0) ? VMIN : p;
  end

  for (genvar s = 1; s <= DW; s++) begin : g_div
    logic [DW:0]   t;
    logic          ge;
    logic [DW:0]   diff;
    side_t         side_nxt;

    always_comb begin
      t    = {rem_r[s-1], dvd_r[s-1][DW-1]};
      diff = t - {1'b0, dsr_r[s-1]};
      ge   = !diff[DW];
      side_nxt = side_r[s-1];
      if (s == 1 && side_r[s-1].kind == OP_MUL) side_nxt.val = mulv;
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        side_r[s] <= side_nxt;
        rem_r[s]  <= ge ? diff[DW-1:0] : t[DW-1:0];
        dvd_r[s]  <= {dvd_r[s-1][DW-2:0], ge};
        dsr_r[s]  <= dsr_r[s-1];
      end
    end
  end

  always_comb begin
    q = dvd_r[DW];
    r = rem_r[DW];
    unique case (side_r[DW].kind)
      OP_UDIV: res = q;
      OP_SDIV: res = side_r[DW].negq ? ~q + DW'(1) : q;
      OP_UREM: res = r;
      OP_SREM: res = side_r[DW].negr ? ~r + DW'(1) : r;
      default: res = side_r[DW].val;
    endcase
    k = side_r[DW].live ? res : side_r[DW].dflt;
  end

endmodule

[sv/sia_merge.sv]
module sia_merge import sia_pkg::*; (
  input  carry_t        car,
  input  logic [DW-1:0] k [NLANE],
  output logic [DW-1:0] lo,
  output logic [DW-1:0] hi,
  output logic [1:0]    tag
);

  carry_t res;

  always_comb begin
    unique case (car.mode)
      MODE_CORNERS: res = mk(smin(smin(k[0], k[1]), smin(k[2], k[3])),
                             smax(smax(k[0], k[1]), smax(k[2], k[3])));
      MODE_DIV: begin
        if (k[0] == k[1]) res = mk(VMIN, VMAX);
        else res = mk(k[0], k[1]);
      end
      default: res = car;
    endcase
    lo  = res.lo;
    hi  = res.hi;
    tag = res.tag;
  end

endmodule

[sv/sia_checker.sv]
`include "signed_interval_alu_macros.svh"

module sia_checker import sia_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [DW-1:0] r_low,
  input logic [DW-1:0] r_high,
  input logic [1:0]    r_tag
);

  // A stalled result stays put.
  `SIA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({r_low, r_high, r_tag}))
  // The input only blocks when the output is holding a result back.
  `SIA_ASSERT_NOW(a_in_block, !in_ready, out_valid && !out_ready)
  // Reset empties the pipeline.
  `SIA_ASSERT_ALWAYS(a_rst_empty, !rst_n, !out_valid)

endmodule

bind signed_interval_alu sia_checker u_sia_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .r_low     (out_if.r_low),
  .r_high    (out_if.r_high),
  .r_tag     (out_if.r_tag)
);
